// ----- rtl/ssds_pkg.sv -----
`timescale 1ns / 1ps

package ssds_pkg;

  // default sizes
  localparam int unsigned MAX_REQUESTS_DEF  = 32;
  localparam int unsigned CYLINDER_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned FIELD_BITS   = 16;
  localparam int unsigned SUM_BITS     = 21;
  localparam int unsigned CFG_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEAD_START  = 2'd1;

  // policy codes
  localparam logic POLICY_FCFS = 1'b0;
  localparam logic POLICY_SSTF = 1'b1;

endpackage

// ----- rtl/shortest_seek_disk_scheduler_unit.sv -----
`timescale 1ns / 1ps

// Disk request scheduler. Requests are loaded one item per cycle into a request
// memory; the item with batch_end set closes the batch and the block then emits
// one result per stored request, in shortest-seek-first order (ties to the earliest
// loaded request) or in load order, as policy_mode selects when batch_end arrives.
// Loading is blocked while a schedule runs. In shortest-seek mode each pick scans
// all n stored entries through the single read port of the request memory, one
// entry per cycle; in arrival-order mode each pick reads only the entry at the
// current step. Requests beyond MaxRequests are dropped and every result of
// that batch shows overflow.
module shortest_seek_disk_scheduler_unit #(
  parameter int unsigned MaxRequests  = ssds_pkg::MAX_REQUESTS_DEF,
  parameter int unsigned CylinderBits = ssds_pkg::CYLINDER_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ssds_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]        cfg_data_i,
  // request items
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [ssds_pkg::FIELD_BITS-1:0]        cylinder_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]        request_id_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]        process_id_i,
  input  logic                                   batch_end_i,
  // result items
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [ssds_pkg::FIELD_BITS-1:0]        from_cylinder_o,
  output logic [ssds_pkg::FIELD_BITS-1:0]        to_cylinder_o,
  output logic [ssds_pkg::FIELD_BITS-1:0]        seek_distance_o,
  output logic [ssds_pkg::FIELD_BITS-1:0]        served_request_id_o,
  output logic [ssds_pkg::FIELD_BITS-1:0]        served_process_id_o,
  output logic [ssds_pkg::SUM_BITS-1:0]          total_seek_o,
  output logic                                   overflow_o,
  output logic                                   last_move_o
);

  localparam int unsigned IdxW  = (MaxRequests > 1) ? $clog2(MaxRequests) : 1;
  localparam int unsigned CntW  = $clog2(MaxRequests + 1);
  localparam int unsigned FldW  = ssds_pkg::FIELD_BITS;
  localparam int unsigned SumW  = ssds_pkg::SUM_BITS;
  localparam int unsigned MemW  = CylinderBits + 2 * FldW;

  // sequencer states
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // control registers
  logic [1:0]             state_q, state_d;
  logic                   policy_q, policy_d;
  logic [FldW-1:0]        head_start_q, head_start_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   drop_q, drop_d;
  logic                   mode_q, mode_d;
  logic                   batch_drop_q, batch_drop_d;
  logic [CntW-1:0]        n_q, n_d;
  logic [CntW-1:0]        step_q, step_d;
  logic [IdxW-1:0]        scan_q, scan_d;
  logic [MaxRequests-1:0] served_q, served_d;
  logic [CylinderBits-1:0] head_q, head_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic                   rd_valid_q, rd_valid_d;
  logic                   found_q, found_d;
  logic                   out_valid_q, out_valid_d;

  // payload registers
  logic [IdxW-1:0]         rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;
  logic [CylinderBits-1:0] best_cyl_q, best_cyl_d;
  logic [CylinderBits-1:0] best_dist_q, best_dist_d;
  logic [FldW-1:0]         best_rid_q, best_rid_d;
  logic [FldW-1:0]         best_pid_q, best_pid_d;
  logic [FldW-1:0]         from_q, from_d;
  logic [FldW-1:0]         to_q, to_d;
  logic [FldW-1:0]         dist_q, dist_d;
  logic [FldW-1:0]         rid_q, rid_d;
  logic [FldW-1:0]         pid_q, pid_d;
  logic [SumW-1:0]         total_q, total_d;
  logic                    ovf_q, ovf_d;
  logic                    last_q, last_d;

  // request memory signals
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [MemW-1:0]         mem_wdata;
  logic                    mem_re;
  logic [MemW-1:0]         mem_rdata;
  logic [CylinderBits-1:0] rd_cyl;
  logic [FldW-1:0]         rd_rid;
  logic [FldW-1:0]         rd_pid;

  logic                    in_fire;
  logic                    has_room;
  logic [IdxW-1:0]         scan_hi;
  logic [CylinderBits-1:0] cand_dist;
  logic [SumW-1:0]         sum_next;
  logic [CntW-1:0]         step_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign has_room    = (count_q < CntW'(MaxRequests));

  // request memory: written while loading, read while scanning
  assign mem_we    = in_fire && has_room;
  assign mem_waddr = count_q[IdxW-1:0];
  assign mem_wdata = {CylinderBits'(cylinder_i), request_id_i, process_id_i};
  assign mem_re    = (state_q == ST_SCAN);

  ssds_ram #(
    .Width (MemW),
    .Depth (MaxRequests)
  ) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (scan_q),
    .rdata_o (mem_rdata)
  );

  assign rd_cyl = mem_rdata[MemW-1 -: CylinderBits];
  assign rd_rid = mem_rdata[2*FldW-1 -: FldW];
  assign rd_pid = mem_rdata[FldW-1:0];

  // scan window: all entries for shortest seek, the current step for arrival order
  assign scan_hi   = (mode_q == ssds_pkg::POLICY_SSTF) ? IdxW'(n_q - 1'b1) : IdxW'(step_q);
  assign cand_dist = (head_q > rd_cyl) ? (head_q - rd_cyl) : (rd_cyl - head_q);
  assign sum_next  = sum_q + SumW'(best_dist_q);
  assign step_inc  = step_q + 1'b1;

  // next-state logic
  always_comb begin
    state_d      = state_q;
    policy_d     = policy_q;
    head_start_d = head_start_q;
    count_d      = count_q;
    drop_d       = drop_q;
    mode_d       = mode_q;
    batch_drop_d = batch_drop_q;
    n_d          = n_q;
    step_d       = step_q;
    scan_d       = scan_q;
    served_d     = served_q;
    head_d       = head_q;
    sum_d        = sum_q;
    rd_valid_d   = 1'b0;
    found_d      = found_q;
    out_valid_d  = out_valid_q;
    rd_idx_d     = rd_idx_q;
    best_idx_d   = best_idx_q;
    best_cyl_d   = best_cyl_q;
    best_dist_d  = best_dist_q;
    best_rid_d   = best_rid_q;
    best_pid_d   = best_pid_q;
    from_d       = from_q;
    to_d         = to_q;
    dist_d       = dist_q;
    rid_d        = rid_q;
    pid_d        = pid_q;
    total_d      = total_q;
    ovf_d        = ovf_q;
    last_d       = last_q;

    // register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssds_pkg::CFG_POLICY_MODE: policy_d = cfg_data_i[0];
        ssds_pkg::CFG_HEAD_START:  head_start_d = cfg_data_i;
        default: ;
      endcase
    end

    // result register drains
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // compare stage: keep the nearest unserved entry, earliest on a tie
    if (rd_valid_q && !served_q[rd_idx_q] && (!found_q || cand_dist < best_dist_q)) begin
      found_d     = 1'b1;
      best_idx_d  = rd_idx_q;
      best_cyl_d  = rd_cyl;
      best_dist_d = cand_dist;
      best_rid_d  = rd_rid;
      best_pid_d  = rd_pid;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (has_room) begin
            count_d = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (batch_end_i) begin
            mode_d       = policy_q;
            head_d       = CylinderBits'(head_start_q);
            sum_d        = '0;
            served_d     = '0;
            step_d       = '0;
            n_d          = has_room ? CntW'(count_q + 1'b1) : count_q;
            batch_drop_d = drop_q || !has_room;
            found_d      = 1'b0;
            scan_d       = '0;
            state_d      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_valid_d = 1'b1;
        rd_idx_d   = scan_q;
        scan_d     = scan_q + 1'b1;
        if (scan_q == scan_hi) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          from_d               = FldW'(head_q);
          to_d                 = FldW'(best_cyl_q);
          dist_d               = FldW'(best_dist_q);
          rid_d                = best_rid_q;
          pid_d                = best_pid_q;
          total_d              = sum_next;
          ovf_d                = batch_drop_q;
          last_d               = (step_inc == n_q);
          head_d               = best_cyl_q;
          sum_d                = sum_next;
          served_d[best_idx_q] = 1'b1;
          step_d               = step_inc;
          found_d              = 1'b0;
          if (step_inc == n_q) begin
            count_d  = '0;
            drop_d   = 1'b0;
            served_d = '0;
            state_d  = ST_LOAD;
          end else begin
            scan_d  = (mode_q == ssds_pkg::POLICY_SSTF) ? '0 : IdxW'(step_inc);
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      policy_q     <= ssds_pkg::POLICY_SSTF;
      head_start_q <= '0;
      count_q      <= '0;
      drop_q       <= 1'b0;
      mode_q       <= ssds_pkg::POLICY_SSTF;
      batch_drop_q <= 1'b0;
      n_q          <= '0;
      step_q       <= '0;
      scan_q       <= '0;
      served_q     <= '0;
      head_q       <= '0;
      sum_q        <= '0;
      rd_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      policy_q     <= policy_d;
      head_start_q <= head_start_d;
      count_q      <= count_d;
      drop_q       <= drop_d;
      mode_q       <= mode_d;
      batch_drop_q <= batch_drop_d;
      n_q          <= n_d;
      step_q       <= step_d;
      scan_q       <= scan_d;
      served_q     <= served_d;
      head_q       <= head_d;
      sum_q        <= sum_d;
      rd_valid_q   <= rd_valid_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_cyl_q  <= best_cyl_d;
    best_dist_q <= best_dist_d;
    best_rid_q  <= best_rid_d;
    best_pid_q  <= best_pid_d;
    from_q      <= from_d;
    to_q        <= to_d;
    dist_q      <= dist_d;
    rid_q       <= rid_d;
    pid_q       <= pid_d;
    total_q     <= total_d;
    ovf_q       <= ovf_d;
    last_q      <= last_d;
  end

  assign out_valid_o         = out_valid_q;
  assign from_cylinder_o     = from_q;
  assign to_cylinder_o       = to_q;
  assign seek_distance_o     = dist_q;
  assign served_request_id_o = rid_q;
  assign served_process_id_o = pid_q;
  assign total_seek_o        = total_q;
  assign overflow_o          = ovf_q;
  assign last_move_o         = last_q;

`ifndef NO_ASSERTIONS
  // the store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxRequests))
    else $error("loaded count beyond capacity");

  // a pick always has a winner once its scan is done
  a_emit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> found_q)
    else $error("emit without a selected entry");

  // one served bit per result already given in this batch
  a_served_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> ($countones(served_q) == int'(step_q)))
    else $error("served map out of step with result count");

  // reads stay inside the loaded part of the store
  a_read_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (CntW'(rd_idx_q) < n_q))
    else $error("read of an entry beyond the batch");
`endif

endmodule

// ----- rtl/ssds_ram.sv -----
`timescale 1ns / 1ps

module ssds_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- dv/shortest_seek_disk_scheduler_checker.sv -----
`timescale 1ns / 1ps

// watches the scheduler channels, predicts every move and compares it
module shortest_seek_disk_scheduler_checker #(
  parameter int unsigned Depth = ssds_pkg::MAX_REQUESTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register writes
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [ssds_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   cfg_data_i,
  // request items
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   cylinder_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   request_id_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   process_id_i,
  input  logic                              batch_end_i,
  // move items
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   from_cylinder_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   to_cylinder_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   seek_distance_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   served_request_id_i,
  input  logic [ssds_pkg::FIELD_BITS-1:0]   served_process_id_i,
  input  logic [ssds_pkg::SUM_BITS-1:0]     total_seek_i,
  input  logic                              overflow_i,
  input  logic                              last_move_i,
  // status for the test top
  output int unsigned                       pending_moves_o,
  output int unsigned                       mismatch_count_o
);

  localparam int unsigned FldW = ssds_pkg::FIELD_BITS;
  localparam int unsigned SumW = ssds_pkg::SUM_BITS;

  typedef struct packed {
    logic [FldW-1:0] from_cyl;
    logic [FldW-1:0] to_cyl;
    logic [FldW-1:0] distance;
    logic [FldW-1:0] req_id;
    logic [FldW-1:0] proc_id;
    logic [SumW-1:0] total;
    logic            overflow;
    logic            last;
  } move_t;

  // shadow registers and request store
  logic            policy     = ssds_pkg::POLICY_SSTF;
  logic [FldW-1:0] head_start = '0;
  logic [FldW-1:0] cyl_store [Depth];
  logic [FldW-1:0] rid_store [Depth];
  logic [FldW-1:0] pid_store [Depth];
  int unsigned     loaded     = 0;
  logic            dropped    = 1'b0;
  move_t           expected_moves [$];
  int unsigned     mismatches = 0;

  function automatic logic [FldW-1:0] seek_span(input logic [FldW-1:0] a,
                                                input logic [FldW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // work out the whole service order of the loaded batch
  task automatic schedule_batch();
    logic [Depth-1:0] served;
    logic [FldW-1:0]  head;
    logic [FldW-1:0]  span;
    logic [FldW-1:0]  best_span;
    logic [SumW-1:0]  sum;
    int unsigned      step;
    int unsigned      idx;
    int unsigned      pick;
    bit               found;
    move_t            mv;
    served = '0;
    head   = head_start;
    sum    = '0;
    for (step = 0; step < loaded; step++) begin
      pick = step;
      // nearest unserved cylinder, strict compare keeps the earliest on a tie
      if (policy == ssds_pkg::POLICY_SSTF) begin
        found     = 1'b0;
        best_span = '0;
        for (idx = 0; idx < loaded; idx++) begin
          span = seek_span(head, cyl_store[idx]);
          if (!served[idx] && (!found || span < best_span)) begin
            found     = 1'b1;
            pick      = idx;
            best_span = span;
          end
        end
      end
      span         = seek_span(head, cyl_store[pick]);
      sum          = sum + SumW'(span);
      mv.from_cyl  = head;
      mv.to_cyl    = cyl_store[pick];
      mv.distance  = span;
      mv.req_id    = rid_store[pick];
      mv.proc_id   = pid_store[pick];
      mv.total     = sum;
      mv.overflow  = dropped;
      mv.last      = (step + 1 == loaded);
      expected_moves.push_back(mv);
      served[pick] = 1'b1;
      head         = cyl_store[pick];
    end
    loaded  = 0;
    dropped = 1'b0;
  endtask

  task automatic compare_move();
    move_t want;
    if (expected_moves.size() == 0) begin
      mismatches++;
      $error("move item arrived with no move expected");
    end else begin
      want = expected_moves.pop_front();
      check_field("from_cylinder", 32'(want.from_cyl), 32'(from_cylinder_i));
      check_field("to_cylinder", 32'(want.to_cyl), 32'(to_cylinder_i));
      check_field("seek_distance", 32'(want.distance), 32'(seek_distance_i));
      check_field("served_request_id", 32'(want.req_id), 32'(served_request_id_i));
      check_field("served_process_id", 32'(want.proc_id), 32'(served_process_id_i));
      check_field("total_seek", 32'(want.total), 32'(total_seek_i));
      check_field("overflow", 32'(want.overflow), 32'(overflow_i));
      check_field("last_move", 32'(want.last), 32'(last_move_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy     = ssds_pkg::POLICY_SSTF;
      head_start = '0;
      loaded     = 0;
      dropped    = 1'b0;
      expected_moves.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ssds_pkg::CFG_POLICY_MODE: policy = cfg_data_i[0];
          ssds_pkg::CFG_HEAD_START:  head_start = cfg_data_i;
          default: ;
        endcase
      end
      // load a request, drop it when the store is full
      if (in_valid_i && in_ready_i) begin
        if (loaded < Depth) begin
          cyl_store[loaded] = cylinder_i;
          rid_store[loaded] = request_id_i;
          pid_store[loaded] = process_id_i;
          loaded++;
        end else begin
          dropped = 1'b1;
        end
        if (batch_end_i) schedule_batch();
      end
      // check a move item
      if (out_valid_i && out_ready_i) compare_move();
    end
    pending_moves_o  <= expected_moves.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- dv/shortest_seek_disk_scheduler_unit_test.sv -----
`timescale 1ns / 1ps

module shortest_seek_disk_scheduler_unit_test;

  localparam int unsigned Depth          = ssds_pkg::MAX_REQUESTS_DEF;
  localparam int unsigned FldW           = ssds_pkg::FIELD_BITS;
  localparam int unsigned ItemTarget     = 180;
  localparam int unsigned CalmItems      = 40;
  localparam int unsigned HoldCycles     = 400;
  localparam int unsigned SettleCycles   = 16;
  localparam int unsigned HoldBatch      = 4;
  localparam int unsigned DropEndBatch   = 2;
  localparam int unsigned FullBatch      = 5;
  localparam int unsigned DropManyBatch  = 9;

  typedef enum int unsigned {SpreadWide, SpreadCluster, SpreadEdges} spread_e;

  logic                              clk         = 1'b0;
  logic                              rst_n       = 1'b0;
  logic                              cfg_valid   = 1'b0;
  logic [ssds_pkg::CFG_IDX_BITS-1:0] cfg_index   = ssds_pkg::CFG_POLICY_MODE;
  logic [FldW-1:0]                   cfg_data    = '0;
  logic                              in_valid    = 1'b0;
  logic [FldW-1:0]                   cylinder    = '0;
  logic [FldW-1:0]                   request_id  = '0;
  logic [FldW-1:0]                   process_id  = '0;
  logic                              batch_end   = 1'b0;
  logic                              out_ready   = 1'b0;

  logic                              cfg_ready;
  logic                              in_ready;
  logic                              out_valid;
  logic [FldW-1:0]                   from_cylinder;
  logic [FldW-1:0]                   to_cylinder;
  logic [FldW-1:0]                   seek_distance;
  logic [FldW-1:0]                   served_request_id;
  logic [FldW-1:0]                   served_process_id;
  logic [ssds_pkg::SUM_BITS-1:0]     total_seek;
  logic                              overflow;
  logic                              last_move;

  int unsigned             pending_moves;
  int unsigned             mismatch_count;
  int unsigned             tx_idle_pct  = 0;
  int unsigned             rx_idle_pct  = 0;
  bit                      hold_off_req = 1'b0;
  int unsigned             items_sent   = 0;

  shortest_seek_disk_scheduler_unit i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .cylinder_i          (cylinder),
    .request_id_i        (request_id),
    .process_id_i        (process_id),
    .batch_end_i         (batch_end),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .from_cylinder_o     (from_cylinder),
    .to_cylinder_o       (to_cylinder),
    .seek_distance_o     (seek_distance),
    .served_request_id_o (served_request_id),
    .served_process_id_o (served_process_id),
    .total_seek_o        (total_seek),
    .overflow_o          (overflow),
    .last_move_o         (last_move)
  );

  shortest_seek_disk_scheduler_checker #(
    .Depth (Depth)
  ) i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .cylinder_i          (cylinder),
    .request_id_i        (request_id),
    .process_id_i        (process_id),
    .batch_end_i         (batch_end),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .from_cylinder_i     (from_cylinder),
    .to_cylinder_i       (to_cylinder),
    .seek_distance_i     (seek_distance),
    .served_request_id_i (served_request_id),
    .served_process_id_i (served_process_id),
    .total_seek_i        (total_seek),
    .overflow_i          (overflow),
    .last_move_i         (last_move),
    .pending_moves_o     (pending_moves),
    .mismatch_count_o    (mismatch_count)
  );

  always #5 clk = ~clk;

  // give up on a hung run
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // move sink: random stall bursts plus one long hold-off on request
  initial begin : move_sink
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one request item, with an optional idle burst first
  task automatic send_request(input logic [FldW-1:0] cyl,
                              input logic [FldW-1:0] rid,
                              input logic [FldW-1:0] pid,
                              input logic            last);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cylinder   <= cyl;
    request_id <= rid;
    process_id <= pid;
    batch_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // stop offering and let every expected move drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_moves != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write both registers once the block is idle; policy word carries junk upper bits
  task automatic configure(input logic policy, input logic [FldW-1:0] head);
    logic [FldW-1:0] policy_word;
    wait_idle();
    policy_word    = FldW'($urandom);
    policy_word[0] = policy;
    cfg_valid <= 1'b1;
    cfg_index <= ssds_pkg::CFG_POLICY_MODE;
    cfg_data  <= policy_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= ssds_pkg::CFG_HEAD_START;
    cfg_data  <= head;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_batch(input int unsigned count, input spread_e spread);
    logic [FldW-1:0] cyl;
    int unsigned     k;
    for (k = 0; k < count; k++) begin
      case (spread)
        SpreadWide: cyl = FldW'($urandom);
        // tight cluster with repeats, lots of seek ties
        SpreadCluster: cyl = 16'h4000 + FldW'($urandom_range(7));
        default: begin
          case ($urandom_range(3))
            0: cyl = '0;
            1: cyl = '1;
            2: cyl = 16'h8000;
            default: cyl = FldW'($urandom);
          endcase
        end
      endcase
      send_request(cyl, FldW'($urandom), FldW'($urandom), k == count - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned     batch_no;
    int unsigned     batch_len;
    logic [FldW-1:0] head;
    batch_no = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: shortest seek from cylinder zero, zero-length first move
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(16'h0000, 16'h0000, 16'h0000, 1'b1);

    // equal cylinders and equal distances on both sides of the head
    configure(ssds_pkg::POLICY_SSTF, 16'd100);
    send_request(16'd150, 16'd1, 16'd11, 1'b0);
    send_request(16'd50,  16'd2, 16'd12, 1'b0);
    send_request(16'd100, 16'd3, 16'd13, 1'b0);
    send_request(16'd100, 16'd4, 16'd14, 1'b0);
    send_request(16'd0,   16'd5, 16'd15, 1'b1);

    // arrival order from the top cylinder
    configure(ssds_pkg::POLICY_FCFS, 16'hFFFF);
    send_request(16'h0000, 16'hAAAA, 16'h5555, 1'b0);
    send_request(16'hFFFF, 16'h5555, 16'hAAAA, 1'b0);
    send_request(16'h0000, 16'h0001, 16'h8000, 1'b0);
    send_request(16'h1234, 16'h8000, 16'h0001, 1'b1);

    // shortest seek from mid-disk, tie one below and one above
    configure(ssds_pkg::POLICY_SSTF, 16'h8000);
    send_request(16'h7FFF, 16'h0F0F, 16'hF0F0, 1'b0);
    send_request(16'h8001, 16'hF0F0, 16'h0F0F, 1'b0);
    send_request(16'hFFFF, 16'h00FF, 16'hFF00, 1'b0);
    send_request(16'h0000, 16'hFF00, 16'h00FF, 1'b1);

    // random batches, store overflow included
    while (items_sent < ItemTarget) begin
      if (items_sent + CalmItems < ItemTarget) begin
        tx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
        rx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (batch_no % 3 == 0) begin
        case ($urandom_range(3))
          0: head = '0;
          1: head = '1;
          default: head = FldW'($urandom);
        endcase
        configure(1'($urandom_range(1)), head);
      end
      // long sink hold-off; the next batch follows at once and backs up
      if (batch_no == HoldBatch) hold_off_req = 1'b1;
      case (batch_no)
        DropEndBatch:  batch_len = Depth + 1;
        FullBatch:     batch_len = Depth;
        DropManyBatch: batch_len = Depth + 4;
        default: begin
          if ($urandom_range(9) == 0) batch_len = $urandom_range(9, Depth - 1);
          else batch_len = $urandom_range(1, 8);
        end
      endcase
      send_batch(batch_len, spread_e'($urandom_range(2)));
      batch_no++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
